/* src/mat_pkg.sv */
`timescale 1ns / 1ps

package mat_pkg;

	localparam int MAX_TAGS_DEF  = 64;
	localparam int WORD_BITS_DEF = 32;
	localparam int FIELD_TAG_W   = 16;

	localparam logic [FIELD_TAG_W-1:0] RESERVED_TAG = 16'hffff;

	typedef enum logic [1:0] {
		CMD_ALLOC     = 2'd0,
		CMD_ALLOC_VER = 2'd1,
		CMD_FREE      = 2'd2,
		CMD_RESET     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFREE  = 2'd1,
		ST_INVALID = 2'd2,
		ST_DOUBLE  = 2'd3
	} status_t;

	typedef struct packed {
		logic                   valid;
		logic [FIELD_TAG_W-1:0] grant;
		status_t                status;
	} result_t;

endpackage

/* src/mat_map.sv */
`timescale 1ns / 1ps

module mat_map #(
	parameter int MAX_TAGS  = mat_pkg::MAX_TAGS_DEF,
	parameter int WORD_BITS = mat_pkg::WORD_BITS_DEF,
	localparam int NUM_WORDS = (MAX_TAGS + WORD_BITS - 1) / WORD_BITS,
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr_all,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    rd_addr,
	output logic [WORD_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_W-1:0]    wr_addr,
	input  logic [WORD_BITS-1:0] wr_data
);

	localparam int PAD_BITS = NUM_WORDS * WORD_BITS - MAX_TAGS;
	localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> PAD_BITS;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [WORD_BITS-1:0] mem_rd_q;
	logic [NUM_WORDS-1:0] valid_q;
	logic                 rd_valid_q;
	logic                 rd_last_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_last_q  <= 1'b0;
		end else begin
			if (clr_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
				rd_last_q  <= (rd_addr == LAST_ADDR);
			end
		end
	end

	assign rd_data = rd_valid_q ? mem_rd_q : (rd_last_q ? LAST_MASK : {WORD_BITS{1'b1}});

endmodule

/* src/mat_find.sv */
`timescale 1ns / 1ps

module mat_find #(
	parameter int WORD_BITS = mat_pkg::WORD_BITS_DEF,
	localparam int BIT_W = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	output logic                 found,
	output logic [BIT_W-1:0]     idx
);

	logic [WORD_BITS-1:0] lowest;

	assign lowest = word & (~word + WORD_BITS'(1));
	assign found  = |word;

	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i]) begin
				idx = idx | BIT_W'(i);
			end
		end
	end

endmodule

/* src/mat_ctrl.sv */
`timescale 1ns / 1ps

module mat_ctrl #(
	parameter int MAX_TAGS  = mat_pkg::MAX_TAGS_DEF,
	parameter int WORD_BITS = mat_pkg::WORD_BITS_DEF,
	localparam int NUM_WORDS = (MAX_TAGS + WORD_BITS - 1) / WORD_BITS,
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [1:0]                          command,
	input  logic [mat_pkg::FIELD_TAG_W-1:0]     tag_to_free,
	output logic                                busy,
	output mat_pkg::result_t                    res,
	output logic                                clr_all,
	output logic                                rd_en,
	output logic [ADDR_W-1:0]                   rd_addr,
	input  logic [WORD_BITS-1:0]                rd_data,
	output logic                                wr_en,
	output logic [ADDR_W-1:0]                   wr_addr,
	output logic [WORD_BITS-1:0]                wr_data
);

	localparam int BIT_W    = $clog2(WORD_BITS);
	localparam int HINT_W   = $clog2(MAX_TAGS + 1);
	localparam int RECIP_SH = 16;
	localparam int RECIP    = (1 << RECIP_SH) / WORD_BITS;
	localparam int PROD_W   = RECIP_SH + ADDR_W + 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
	localparam logic [BIT_W-1:0]  TOP_BIT   = BIT_W'(WORD_BITS - 1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_DIV  = 6'b000010,
		S_LOC  = 6'b000100,
		S_FCHK = 6'b001000,
		S_HCHK = 6'b010000,
		S_SCAN = 6'b100000
	} state_t;

	state_t              state_q, state_d;
	logic [HINT_W-1:0]   hint_q, hint_d;
	logic [ADDR_W-1:0]   hint_word_q, hint_word_d;
	logic [BIT_W-1:0]    hint_bit_q, hint_bit_d;
	logic [HINT_W-1:0]   tag_q, tag_d;
	logic [ADDR_W-1:0]   quot_q, quot_d;
	logic [ADDR_W-1:0]   fword_q, fword_d;
	logic [BIT_W-1:0]    fbit_q, fbit_d;
	logic [ADDR_W-1:0]   scan_q, scan_d;
	logic [HINT_W-1:0]   base_q, base_d;

	logic [PROD_W-1:0]   prod;
	logic [HINT_W-1:0]   rem0;
	logic                find_found;
	logic [BIT_W-1:0]    find_idx;
	logic                hint_set;
	logic [HINT_W-1:0]   g_tag;
	logic [ADDR_W-1:0]   g_word;
	logic [BIT_W-1:0]    g_bit;
	mat_pkg::cmd_t       cmd;

	assign cmd  = mat_pkg::cmd_t'(command);
	assign prod = PROD_W'(tag_q) * PROD_W'(RECIP);
	assign rem0 = tag_q - HINT_W'(HINT_W'(quot_q) * HINT_W'(WORD_BITS));
	assign busy = (state_q != S_IDLE);

	mat_find #(
		.WORD_BITS (WORD_BITS)
	) u_find (
		.word  (rd_data),
		.found (find_found),
		.idx   (find_idx)
	);

	always_comb begin
		state_d     = state_q;
		hint_d      = hint_q;
		hint_word_d = hint_word_q;
		hint_bit_d  = hint_bit_q;
		tag_d       = tag_q;
		quot_d      = quot_q;
		fword_d     = fword_q;
		fbit_d      = fbit_q;
		scan_d      = scan_q;
		base_d      = base_q;
		res         = '{valid: 1'b0, grant: '0, status: mat_pkg::ST_OK};
		clr_all     = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = '0;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = '0;
		hint_set    = 1'b0;
		g_tag       = '0;
		g_word      = '0;
		g_bit       = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (cmd)
						mat_pkg::CMD_ALLOC: begin
							rd_en = 1'b1;
							if (hint_q < HINT_W'(MAX_TAGS)) begin
								rd_addr = hint_word_q;
								state_d = S_HCHK;
							end else begin
								scan_d  = '0;
								base_d  = '0;
								state_d = S_SCAN;
							end
						end
						mat_pkg::CMD_ALLOC_VER: begin
							res.valid = 1'b1;
							res.grant = mat_pkg::RESERVED_TAG;
						end
						mat_pkg::CMD_FREE: begin
							if (tag_to_free == mat_pkg::RESERVED_TAG) begin
								res.valid = 1'b1;
							end else if (tag_to_free >= mat_pkg::FIELD_TAG_W'(MAX_TAGS)) begin
								res.valid  = 1'b1;
								res.status = mat_pkg::ST_INVALID;
							end else begin
								tag_d   = HINT_W'(tag_to_free);
								state_d = S_DIV;
							end
						end
						mat_pkg::CMD_RESET: begin
							clr_all     = 1'b1;
							hint_d      = '0;
							hint_word_d = '0;
							hint_bit_d  = '0;
							res.valid   = 1'b1;
						end
						default: begin
							res.valid = 1'b0;
						end
					endcase
				end
			end
			S_DIV: begin
				quot_d  = prod[RECIP_SH +: ADDR_W];
				state_d = S_LOC;
			end
			S_LOC: begin
				rd_en = 1'b1;
				if (rem0 >= HINT_W'(WORD_BITS)) begin
					fword_d = quot_q + ADDR_W'(1);
					fbit_d  = BIT_W'(rem0 - HINT_W'(WORD_BITS));
				end else begin
					fword_d = quot_q;
					fbit_d  = BIT_W'(rem0);
				end
				rd_addr = fword_d;
				state_d = S_FCHK;
			end
			S_FCHK: begin
				res.valid = 1'b1;
				if (rd_data[fbit_q]) begin
					res.status = mat_pkg::ST_DOUBLE;
				end else begin
					wr_en   = 1'b1;
					wr_addr = fword_q;
					wr_data = rd_data | (WORD_BITS'(1) << fbit_q);
					if (hint_q > tag_q) begin
						hint_d      = tag_q;
						hint_word_d = fword_q;
						hint_bit_d  = fbit_q;
					end
				end
				state_d = S_IDLE;
			end
			S_HCHK: begin
				if (rd_data[hint_bit_q]) begin
					wr_en     = 1'b1;
					wr_addr   = hint_word_q;
					wr_data   = rd_data & ~(WORD_BITS'(1) << hint_bit_q);
					res.valid = 1'b1;
					res.grant = mat_pkg::FIELD_TAG_W'(hint_q);
					hint_set  = 1'b1;
					g_tag     = hint_q;
					g_word    = hint_word_q;
					g_bit     = hint_bit_q;
					state_d   = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					scan_d  = '0;
					base_d  = '0;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (find_found) begin
					wr_en     = 1'b1;
					wr_addr   = scan_q;
					wr_data   = rd_data & ~(WORD_BITS'(1) << find_idx);
					g_tag     = base_q + HINT_W'(find_idx);
					g_word    = scan_q;
					g_bit     = find_idx;
					hint_set  = 1'b1;
					res.valid = 1'b1;
					res.grant = mat_pkg::FIELD_TAG_W'(g_tag);
					state_d   = S_IDLE;
				end else if (scan_q == LAST_ADDR) begin
					res.valid  = 1'b1;
					res.status = mat_pkg::ST_NOFREE;
					state_d    = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = scan_q + ADDR_W'(1);
					scan_d  = rd_addr;
					base_d  = base_q + HINT_W'(WORD_BITS);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (hint_set) begin
			hint_d = g_tag + HINT_W'(1);
			if (g_bit == TOP_BIT) begin
				hint_word_d = g_word + ADDR_W'(1);
				hint_bit_d  = '0;
			end else begin
				hint_word_d = g_word;
				hint_bit_d  = g_bit + BIT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hint_q      <= '0;
			hint_word_q <= '0;
			hint_bit_q  <= '0;
		end else begin
			state_q     <= state_d;
			hint_q      <= hint_d;
			hint_word_q <= hint_word_d;
			hint_bit_q  <= hint_bit_d;
		end
	end

	always_ff @(posedge clk) begin
		tag_q   <= tag_d;
		quot_q  <= quot_d;
		fword_q <= fword_d;
		fbit_q  <= fbit_d;
		scan_q  <= scan_d;
		base_q  <= base_d;
	end

endmodule

/* src/message_tag_allocator_unit.sv */
`timescale 1ns / 1ps
// Version allocate, reset and rejected frees are answered from idle; an allocate checks the
// hint bit, or scans one bitmap word per cycle when that is taken or past the end; a free
// divides the tag, locates its bit and marks it free unless it already is.
// Throughput: one transaction at a time; the next start is taken in the done cycle.
// Reset: arst_n marks every tag free and clears the hint; results cannot be stalled.
module message_tag_allocator_unit #(
	parameter int MAX_TAGS  = mat_pkg::MAX_TAGS_DEF,
	parameter int WORD_BITS = mat_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      command,
	input  logic [mat_pkg::FIELD_TAG_W-1:0] tag_to_free,
	output logic                            done,
	output logic [mat_pkg::FIELD_TAG_W-1:0] granted_tag,
	output logic [1:0]                      status
);

	localparam int NUM_WORDS = (MAX_TAGS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

	mat_pkg::result_t                res;
	logic                            clr_all;
	logic                            rd_en;
	logic [ADDR_W-1:0]               rd_addr;
	logic [WORD_BITS-1:0]            rd_data;
	logic                            wr_en;
	logic [ADDR_W-1:0]               wr_addr;
	logic [WORD_BITS-1:0]            wr_data;
	logic                            done_q;
	logic [mat_pkg::FIELD_TAG_W-1:0] granted_tag_q;
	logic [1:0]                      status_q;

	mat_map #(
		.MAX_TAGS  (MAX_TAGS),
		.WORD_BITS (WORD_BITS)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr_all (clr_all),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	mat_ctrl #(
		.MAX_TAGS  (MAX_TAGS),
		.WORD_BITS (WORD_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.tag_to_free (tag_to_free),
		.busy        (busy),
		.res         (res),
		.clr_all     (clr_all),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			granted_tag_q <= res.grant;
			status_q      <= res.status;
		end
	end

	assign done        = done_q;
	assign granted_tag = granted_tag_q;
	assign status      = status_q;

	a_version_grant: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == mat_pkg::CMD_ALLOC_VER
			|=> done && granted_tag == mat_pkg::RESERVED_TAG && status == mat_pkg::ST_OK)
		else $error("version allocate did not return the reserved tag");

	a_nofree_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == mat_pkg::ST_NOFREE |-> granted_tag == '0)
		else $error("no-free result carries a tag");

	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> granted_tag < mat_pkg::FIELD_TAG_W'(MAX_TAGS)
			|| granted_tag == mat_pkg::RESERVED_TAG)
		else $error("granted tag beyond the limit");

	a_free_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == mat_pkg::CMD_FREE
			&& tag_to_free < mat_pkg::FIELD_TAG_W'(MAX_TAGS) |=> busy && !done)
		else $error("in-range free did not enter the lookup");

endmodule

/* tb/message_tag_allocator_unit_tb.sv */
`timescale 1ns / 1ps

module message_tag_allocator_unit_tb;

	localparam int TAG_COUNT   = mat_pkg::MAX_TAGS_DEF;
	localparam int WB          = mat_pkg::WORD_BITS_DEF;
	localparam int TAG_W       = mat_pkg::FIELD_TAG_W;
	localparam int NUM_WORDS   = (TAG_COUNT + WB - 1) / WB;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [TAG_W-1:0]  tag;
		mat_pkg::status_t  st;
	} grant_rec_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       command;
	logic [TAG_W-1:0] tag_to_free;
	logic             done;
	logic [TAG_W-1:0] granted_tag;
	logic [1:0]       status;

	bit [WB-1:0] free_map [NUM_WORDS];
	int          free_hint;
	grant_rec_t  expected_grants [$];
	int          fail_count;
	int          cycle_count;
	int          burst_left;

	message_tag_allocator_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.tag_to_free(tag_to_free),
		.done       (done),
		.granted_tag(granted_tag),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit tag_free(int t);
		if (t < 0 || t >= TAG_COUNT) return 1'b0;
		return free_map[t / WB][t % WB];
	endfunction

	function automatic void mark_tag(int t, bit is_free);
		if (t >= 0 && t < TAG_COUNT) free_map[t / WB][t % WB] = is_free;
	endfunction

	function automatic void clear_map();
		int t;
		for (t = 0; t < NUM_WORDS * WB; t++) free_map[t / WB][t % WB] = (t < TAG_COUNT);
		free_hint = 0;
	endfunction

	function automatic void predict_grant(mat_pkg::cmd_t c, logic [TAG_W-1:0] t,
			output grant_rec_t r);
		int  i;
		bit  found;
		r.tag = '0;
		r.st  = mat_pkg::ST_OK;
		unique case (c)
			mat_pkg::CMD_ALLOC: begin
				if (free_hint < TAG_COUNT && tag_free(free_hint)) begin
					r.tag = TAG_W'(free_hint);
					mark_tag(free_hint, 1'b0);
					free_hint = free_hint + 1;
				end else begin
					found = 1'b0;
					for (i = 0; i < TAG_COUNT; i++) begin
						if (!found && tag_free(i)) begin
							found = 1'b1;
							r.tag = TAG_W'(i);
							mark_tag(i, 1'b0);
							free_hint = i + 1;
						end
					end
					if (!found) r.st = mat_pkg::ST_NOFREE;
				end
			end
			mat_pkg::CMD_ALLOC_VER: r.tag = mat_pkg::RESERVED_TAG;
			mat_pkg::CMD_FREE: begin
				if (t != mat_pkg::RESERVED_TAG) begin
					if (int'(t) >= TAG_COUNT) r.st = mat_pkg::ST_INVALID;
					else if (tag_free(int'(t))) r.st = mat_pkg::ST_DOUBLE;
					else begin
						if (free_hint > int'(t)) free_hint = int'(t);
						mark_tag(int'(t), 1'b1);
					end
				end
			end
			default: clear_map();
		endcase
	endfunction

	// Pick a tag currently held by the block, falling back to any legal tag.
	function automatic int pick_taken_tag();
		int base;
		int i;
		base = $urandom_range(0, TAG_COUNT - 1);
		for (i = 0; i < TAG_COUNT; i++)
			if (!tag_free((base + i) % TAG_COUNT)) return (base + i) % TAG_COUNT;
		return base;
	endfunction

	task automatic send_cmd(mat_pkg::cmd_t c, logic [TAG_W-1:0] t);
		grant_rec_t r;
		int gap;
		start       <= 1'b1;
		command     <= c;
		tag_to_free <= t;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_grant(c, t, r);
		expected_grants.push_back(r);
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic test_version_and_rejects();
		send_cmd(mat_pkg::CMD_ALLOC_VER, 16'h0000);
		send_cmd(mat_pkg::CMD_FREE, mat_pkg::RESERVED_TAG);
		send_cmd(mat_pkg::CMD_FREE, TAG_W'(TAG_COUNT));
		send_cmd(mat_pkg::CMD_FREE, 16'hfffe);
		send_cmd(mat_pkg::CMD_FREE, 16'h8000);
		send_cmd(mat_pkg::CMD_FREE, 16'h0000);
		send_cmd(mat_pkg::CMD_FREE, TAG_W'(TAG_COUNT - 1));
		send_cmd(mat_pkg::CMD_ALLOC_VER, 16'hffff);
	endtask

	task automatic test_hint_moves();
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_FREE, 16'd1);
		send_cmd(mat_pkg::CMD_FREE, 16'd1);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_FREE, 16'd0);
		send_cmd(mat_pkg::CMD_FREE, 16'd2);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_RESET, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
	endtask

	task automatic test_map_full();
		int i;
		send_cmd(mat_pkg::CMD_RESET, 16'h0000);
		for (i = 0; i < TAG_COUNT; i++) send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_FREE, 16'd40);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_FREE, TAG_W'(TAG_COUNT - 1));
		send_cmd(mat_pkg::CMD_FREE, 16'd0);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		send_cmd(mat_pkg::CMD_ALLOC, 16'h0000);
		for (i = 0; i < 8; i++) send_cmd(mat_pkg::CMD_FREE, TAG_W'(pick_taken_tag()));
		send_cmd(mat_pkg::CMD_RESET, 16'h0000);
	endtask

	// Every 80 items the allocate weight is redrawn, so phases lean towards filling or draining the map.
	task automatic test_random_mix(int n_items);
		int  i;
		int  x;
		int  alloc_w;
		logic [TAG_W-1:0] t;
		alloc_w = 50;
		for (i = 0; i < n_items; i++) begin
			if (i % 80 == 0) alloc_w = $urandom_range(15, 80);
			x = $urandom_range(0, 99);
			t = TAG_W'($urandom_range(0, 16'hffff));
			if (x < 2) send_cmd(mat_pkg::CMD_RESET, t);
			else if (x < 9) send_cmd(mat_pkg::CMD_ALLOC_VER, t);
			else if (x < 9 + alloc_w) send_cmd(mat_pkg::CMD_ALLOC, t);
			else begin
				x = $urandom_range(0, 99);
				if (x < 60) t = TAG_W'(pick_taken_tag());
				else if (x < 85) t = TAG_W'($urandom_range(0, TAG_COUNT - 1));
				else if (x < 95) t = TAG_W'($urandom_range(TAG_COUNT, 16'hfffe));
				else t = mat_pkg::RESERVED_TAG;
				send_cmd(mat_pkg::CMD_FREE, t);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_grants.size() == 0) begin
				$error("unexpected transaction: granted_tag %0h status %0d", granted_tag,
					status);
				fail_count++;
			end else begin
				grant_rec_t r;
				r = expected_grants.pop_front();
				if (granted_tag !== r.tag) begin
					$error("granted_tag: expected %0h, actual %0h", r.tag, granted_tag);
					fail_count++;
				end
				if (status !== r.st) begin
					$error("status: expected %0d, actual %0d", r.st, status);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		fail_count  = 0;
		cycle_count = 0;
		burst_left  = $urandom_range(1, 24);
		clear_map();
		arst_n      <= 1'b0;
		start       <= 1'b0;
		command     <= mat_pkg::CMD_ALLOC;
		tag_to_free <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_version_and_rejects();
		test_hint_moves();
		test_map_full();
		test_random_mix(1000);
		start <= 1'b0;

		while (expected_grants.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_grants.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
